>>> sv/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg - shared types, constants and microprogram for the soft clipper
// Holds the control word layout, the step addresses and the program ROM.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int CONST_BITS    = 28;
  // Blend weight h and clip level R at 28 fraction bits
  localparam longint H_Q28 = 64'sd198396655;
  localparam longint R_Q28 = 64'sd256353870;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  // Step addresses of the microprogram
  localparam step_t ST_WAIT = 5'd0;
  localparam step_t ST_PCHK = 5'd1;
  localparam step_t ST_PSEL = 5'd2;
  localparam step_t ST_PMH  = 5'd3;
  localparam step_t ST_PMX  = 5'd4;
  localparam step_t ST_PWB  = 5'd5;
  localparam step_t ST_PXC  = 5'd6;
  localparam step_t ST_PXM  = 5'd7;
  localparam step_t ST_PXW  = 5'd8;
  localparam step_t ST_NCHK = 5'd9;
  localparam step_t ST_NSEL = 5'd10;
  localparam step_t ST_NMH  = 5'd11;
  localparam step_t ST_NMX  = 5'd12;
  localparam step_t ST_NWB  = 5'd13;
  localparam step_t ST_NXC  = 5'd14;
  localparam step_t ST_NXM  = 5'd15;
  localparam step_t ST_NXW  = 5'd16;
  localparam step_t ST_EMIT = 5'd17;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_POS,
    C_NEG,
    C_X_LT_HELD,
    C_X_GT_HELD,
    C_X_GT_R,
    C_X_LT_NR,
    C_OUT_FREE
  } cond_e;

  typedef enum logic [1:0] {
    OPND_X,
    OPND_HELD,
    OPND_RP,
    OPND_RN
  } opnd_e;

  typedef enum logic {
    DEST_HELD,
    DEST_X
  } dest_e;

  typedef struct packed {
    cond_e cond;
    step_t tgt;
    step_t nxt;
    logic  acc;
    logic  mul;
    opnd_e opa;
    opnd_e opb;
    logic  wb;
    dest_e dest;
    logic  set_pos;
    logic  set_neg;
    logic  emit;
  } uword_t;

  typedef struct packed {
    logic  ld_x;
    logic  mul;
    opnd_e opa;
    opnd_e opb;
    logic  wb;
    dest_e dest;
    logic  set_pos;
    logic  set_neg;
    logic  commit;
  } dp_ctl_t;

  typedef struct packed {
    logic pos;
    logic neg;
    logic x_lt_held;
    logic x_gt_held;
    logic x_gt_r;
    logic x_lt_nr;
  } dp_stat_t;

  // Program ROM: jump to tgt when cond holds, else go to nxt
  function automatic uword_t lsc_ucode(input step_t s);
    uword_t u;
    u = '{cond: C_ALWAYS, tgt: ST_WAIT, nxt: ST_WAIT, acc: 1'b0, mul: 1'b0,
          opa: OPND_X, opb: OPND_X, wb: 1'b0, dest: DEST_HELD,
          set_pos: 1'b0, set_neg: 1'b0, emit: 1'b0};
    unique case (s)
      ST_WAIT: begin
        u.cond = C_IN_VALID; u.tgt = ST_PCHK; u.nxt = ST_WAIT; u.acc = 1'b1;
      end
      ST_PCHK: begin
        u.cond = C_POS; u.tgt = ST_PSEL; u.nxt = ST_PXC;
      end
      ST_PSEL: begin
        u.cond = C_X_LT_HELD; u.tgt = ST_PMX; u.nxt = ST_PMH;
      end
      ST_PMH: begin
        u.tgt = ST_PWB; u.mul = 1'b1; u.opa = OPND_HELD; u.opb = OPND_RP;
      end
      ST_PMX: begin
        u.tgt = ST_PWB; u.mul = 1'b1; u.opa = OPND_RP; u.opb = OPND_X;
      end
      ST_PWB: begin
        u.tgt = ST_PXC; u.wb = 1'b1; u.dest = DEST_HELD;
      end
      ST_PXC: begin
        u.cond = C_X_GT_R; u.tgt = ST_PXM; u.nxt = ST_NCHK; u.set_pos = 1'b1;
      end
      ST_PXM: begin
        u.tgt = ST_PXW; u.mul = 1'b1; u.opa = OPND_RP; u.opb = OPND_HELD;
      end
      ST_PXW: begin
        u.tgt = ST_NCHK; u.wb = 1'b1; u.dest = DEST_X;
      end
      ST_NCHK: begin
        u.cond = C_NEG; u.tgt = ST_NSEL; u.nxt = ST_NXC;
      end
      ST_NSEL: begin
        u.cond = C_X_GT_HELD; u.tgt = ST_NMX; u.nxt = ST_NMH;
      end
      ST_NMH: begin
        u.tgt = ST_NWB; u.mul = 1'b1; u.opa = OPND_HELD; u.opb = OPND_RN;
      end
      ST_NMX: begin
        u.tgt = ST_NWB; u.mul = 1'b1; u.opa = OPND_RN; u.opb = OPND_X;
      end
      ST_NWB: begin
        u.tgt = ST_NXC; u.wb = 1'b1; u.dest = DEST_HELD;
      end
      ST_NXC: begin
        u.cond = C_X_LT_NR; u.tgt = ST_NXM; u.nxt = ST_EMIT; u.set_neg = 1'b1;
      end
      ST_NXM: begin
        u.tgt = ST_NXW; u.mul = 1'b1; u.opa = OPND_RN; u.opb = OPND_HELD;
      end
      ST_NXW: begin
        u.tgt = ST_EMIT; u.wb = 1'b1; u.dest = DEST_X;
      end
      ST_EMIT: begin
        u.cond = C_OUT_FREE; u.tgt = ST_WAIT; u.nxt = ST_EMIT; u.emit = 1'b1;
      end
      default: begin
        u.cond = C_ALWAYS; u.tgt = ST_WAIT;
      end
    endcase
    return u;
  endfunction

endpackage

>>> sv/lsc_dp.sv
// ----------------------------------------------------------------------------
// lsc_dp - clipper datapath
// Clamp, operand select, one shared blend multiplier, rounding write-back.
// ----------------------------------------------------------------------------
module lsc_dp #(
  parameter int FRAC_BITS = lsc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lsc_pkg::dp_ctl_t            ctl_i,
  input  logic signed [31:0]          sample_i,
  output lsc_pkg::dp_stat_t           stat_o,
  output logic signed [FRAC_BITS+2:0] held_sat_o
);
  import lsc_pkg::*;

  localparam int W   = FRAC_BITS + 4;
  localparam int PW  = W + FRAC_BITS + 2;
  localparam int CSH = CONST_BITS - FRAC_BITS;
  localparam longint CHALF = (longint'(1) << CSH) >>> 1;
  localparam longint H_L   = (H_Q28 + CHALF) >>> CSH;
  localparam longint R_L   = (R_Q28 + CHALF) >>> CSH;
  localparam logic signed [W-1:0]       LIM_W  = W'(longint'(1) << (FRAC_BITS + 2));
  localparam logic signed [32:0]        LIM_IN = 33'(longint'(1) << (FRAC_BITS + 2));
  localparam logic signed [W-1:0]       R_W    = W'(R_L);
  localparam logic signed [W-1:0]       RN_W   = W'(-R_L);
  localparam logic signed [FRAC_BITS:0] H_S    = (FRAC_BITS + 1)'(H_L);
  localparam logic signed [PW-1:0]      RND    = PW'(longint'(1) << (FRAC_BITS - 1));

  logic signed [W-1:0]  x_q, held_q, base_q;
  logic                 pos_q, neg_q;
  logic signed [PW-1:0] prod_q;

  logic signed [32:0]   s_ext;
  logic signed [W-1:0]  x_clamp, op_a, op_b, wb_val;
  logic signed [W:0]    diff;
  logic signed [PW-1:0] prod_d, rsum, rsh;

  // clamp to +/-4.0
  always_comb begin
    s_ext = $signed({sample_i[31], sample_i});
    if (s_ext > LIM_IN) begin
      x_clamp = LIM_W;
    end else if (s_ext < -LIM_IN) begin
      x_clamp = -LIM_W;
    end else begin
      x_clamp = s_ext[W-1:0];
    end
  end

  always_comb begin
    unique case (ctl_i.opa)
      OPND_X:    op_a = x_q;
      OPND_HELD: op_a = held_q;
      OPND_RP:   op_a = R_W;
      OPND_RN:   op_a = RN_W;
      default:   op_a = x_q;
    endcase
    unique case (ctl_i.opb)
      OPND_X:    op_b = x_q;
      OPND_HELD: op_b = held_q;
      OPND_RP:   op_b = R_W;
      OPND_RN:   op_b = RN_W;
      default:   op_b = x_q;
    endcase
  end

  // blend(a, b) = b + round((a - b) * h)
  assign diff   = $signed({op_a[W-1], op_a}) - $signed({op_b[W-1], op_b});
  assign prod_d = PW'(diff) * PW'(H_S);
  assign rsum   = prod_q + RND;
  assign rsh    = rsum >>> FRAC_BITS;
  assign wb_val = base_q + rsh[W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= prod_d;
      base_q <= op_b;
    end
    if (ctl_i.ld_x) begin
      x_q <= x_clamp;
    end else if (ctl_i.wb && ctl_i.dest == DEST_X) begin
      x_q <= wb_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pos_q  <= 1'b0;
      neg_q  <= 1'b0;
    end else begin
      if (ctl_i.commit) begin
        held_q <= x_q;
      end else if (ctl_i.wb && ctl_i.dest == DEST_HELD) begin
        held_q <= wb_val;
      end
      if (ctl_i.set_pos) begin
        pos_q <= (x_q > R_W);
      end
      if (ctl_i.set_neg) begin
        neg_q <= (x_q < RN_W);
      end
    end
  end

  assign stat_o = '{pos: pos_q, neg: neg_q,
                    x_lt_held: (x_q < held_q), x_gt_held: (x_q > held_q),
                    x_gt_r: (x_q > R_W), x_lt_nr: (x_q < RN_W)};

  // only a held value of exactly +4.0 needs saturating
  assign held_sat_o = (held_q >= LIM_W) ? {1'b0, {(FRAC_BITS + 2){1'b1}}}
                                        : held_q[FRAC_BITS+2:0];

  a_wb_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.wb |-> (wb_val <= LIM_W && wb_val >= -LIM_W))
    else $error("blend result outside +/-4.0");

  a_commit_moves_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.commit |=> (held_q == $past(x_q)))
    else $error("held sample not taken from processed sample");

endmodule

>>> sv/lsc_seq.sv
// ----------------------------------------------------------------------------
// lsc_seq - microcode sequencer
// Step counter over the program ROM with conditional jumps.
// ----------------------------------------------------------------------------
module lsc_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_free_i,
  input  lsc_pkg::dp_stat_t stat_i,
  output logic              in_ready_o,
  output lsc_pkg::dp_ctl_t  ctl_o
);
  import lsc_pkg::*;

  step_t  step_q, step_d;
  uword_t uw;
  logic   take;

  assign uw = lsc_ucode(step_q);

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:    take = 1'b1;
      C_IN_VALID:  take = in_valid_i;
      C_POS:       take = stat_i.pos;
      C_NEG:       take = stat_i.neg;
      C_X_LT_HELD: take = stat_i.x_lt_held;
      C_X_GT_HELD: take = stat_i.x_gt_held;
      C_X_GT_R:    take = stat_i.x_gt_r;
      C_X_LT_NR:   take = stat_i.x_lt_nr;
      C_OUT_FREE:  take = out_free_i;
      default:     take = 1'b1;
    endcase
    step_d = take ? uw.tgt : uw.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assign in_ready_o = uw.acc;
  assign ctl_o = '{ld_x: uw.acc & in_valid_i, mul: uw.mul, opa: uw.opa, opb: uw.opb,
                   wb: uw.wb, dest: uw.dest, set_pos: uw.set_pos,
                   set_neg: uw.set_neg, commit: uw.emit & out_free_i};

  a_mul_then_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uw.mul |=> uw.wb)
    else $error("multiply step not followed by write-back");

endmodule

>>> sv/lookahead_soft_clipper.sv
// ----------------------------------------------------------------------------
// lookahead_soft_clipper - one-sample lookahead soft clipper
// Clamps each sample to +/-4.0, softens crossings of the clip level by
// blending with the neighbouring sample, and emits the held sample one
// beat late, saturated to +/-4.0.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------
//  in      | sink      | in_valid_i / in_ready_o   | sample_in_i  (32 b, s)
//  out     | source    | out_valid_o / out_ready_i | sample_out_o (F+3 b, s)
//
//  Steps: the microprogram visits six fixed steps (accept, four checks, emit);
//    a pending-flag blend adds three (select, multiply, round and write back)
//    and a crossing blend adds two (multiply, round and write back) on the
//    single shared multiplier. The two flags never both set, and a positive
//    crossing never leads into a negative one, so at most one blend of each
//    kind runs per beat.
//  Reset: asynchronous, active low; held sample and clip flags clear, so the
//    first output beat is zero.
//  Stalls: the output register holds the result while the next input beat
//    is accepted and processed; the sequencer holds at its emit step only
//    while that register is still full and not being taken.
//
module lookahead_soft_clipper #(
  parameter int FRAC_BITS = lsc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [31:0]          sample_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [FRAC_BITS+2:0] sample_out_o
);
  import lsc_pkg::*;

  dp_ctl_t                     ctl;
  dp_stat_t                    stat;
  logic signed [FRAC_BITS+2:0] held_sat;
  logic signed [FRAC_BITS+2:0] out_q;
  logic                        out_valid_q;
  logic                        out_free;

  // output register may be refilled in the cycle it drains
  assign out_free = !out_valid_q || out_ready_i;

  lsc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .ctl_o      (ctl)
  );

  lsc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sample_i   (sample_in_i),
    .stat_o     (stat),
    .held_sat_o (held_sat)
  );

  // hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.commit) begin
      out_q <= held_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  a_one_beat_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat accepted while one is in progress");

  a_commit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.commit |-> (!out_valid_q || out_ready_i))
    else $error("result written over an untaken output beat");

endmodule

>>> bench/lookahead_soft_clipper_tb.sv
// ----------------------------------------------------------------------------
// lookahead_soft_clipper_tb - self-checking bench for the lookahead soft clipper
// Feeds directed corner samples, then random walks that cross the clip level,
// and checks every output beat against a bit-accurate clip predictor, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module lookahead_soft_clipper_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FB     = lsc_pkg::FRAC_BITS_DEF;
  localparam int     SH     = lsc_pkg::CONST_BITS - FB;
  localparam longint ONE    = 64'sd1 <<< FB;
  // Blend weight and clip level, rounded to nearest from 28 fraction bits
  localparam longint WH     = (lsc_pkg::H_Q28 + (64'sd1 <<< (SH - 1))) >>> SH;
  localparam longint WS     = ONE - WH;
  localparam longint LVL    = (lsc_pkg::R_Q28 + (64'sd1 <<< (SH - 1))) >>> SH;
  localparam longint LIM    = 64'sd4 <<< FB;
  localparam int     N_RAND = 1150;

  typedef logic signed [FB+2:0] out_t;

  // Bit-accurate clip predictor plus the queue of output samples still owed
  class clip_tracker;
    longint prev_sample;
    bit     pos_pending;
    bit     neg_pending;
    out_t   owed_out[$];
    int     errors;
    int     matched;
    int     pos_hits;
    int     neg_hits;

    function new();
      prev_sample = 0;
      pos_pending = 1'b0;
      neg_pending = 1'b0;
      errors      = 0;
      matched     = 0;
      pos_hits    = 0;
      neg_hits    = 0;
    endfunction

    // a*h + b*(1-h), exact, then rounded once with ties upward
    function longint weigh(longint a, longint b);
      return (a * WH + b * WS + (ONE >>> 1)) >>> FB;
    endfunction

    function void take_sample(logic signed [31:0] s);
      longint x;
      longint y;
      x = longint'(s);
      if (x > LIM) x = LIM;
      if (x < -LIM) x = -LIM;

      if (pos_pending)
        prev_sample = (x < prev_sample) ? weigh(LVL, x) : weigh(prev_sample, LVL);
      pos_pending = 1'b0;
      if (x > LVL) begin
        pos_pending = 1'b1;
        pos_hits++;
        x = weigh(LVL, prev_sample);
      end

      // The negative side sees what the positive side left behind
      if (neg_pending)
        prev_sample = (x > prev_sample) ? weigh(-LVL, x) : weigh(prev_sample, -LVL);
      neg_pending = 1'b0;
      if (x < -LVL) begin
        neg_pending = 1'b1;
        neg_hits++;
        x = weigh(-LVL, prev_sample);
      end

      y = prev_sample;
      if (y > LIM - 1) y = LIM - 1;
      if (y < -LIM) y = -LIM;
      owed_out.push_back(out_t'(y));
      prev_sample = x;
    endfunction

    function void match_output(out_t got);
      out_t want;
      if (owed_out.size() == 0) begin
        errors++;
        $display("%0t: output beat with nothing owed, got %0d", $time, got);
        return;
      end
      want = owed_out.pop_front();
      matched++;
      if (got !== want) begin
        errors++;
        $display("%0t: sample_out mismatch, expected %0d, got %0d", $time, want, got);
      end
    endfunction

    function int outstanding();
      return owed_out.size();
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic signed [31:0]   sample_in_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_t                 sample_out_o;

  clip_tracker tracker = new();
  bit          steady  = 1'b0;   // no idling on either side while set
  int          sent    = 0;

  // Corners: field extremes, clamp limits, the level itself and one lsb past
  // it, repeated crossings, and a positive crossing straight into a negative
  logic signed [31:0] corner_samples [23] = '{
    32'sd0,
    32'sh7FFF_FFFF,
    32'sh8000_0000,
    32'(LIM),
    32'(LIM + 1),
    32'(-LIM),
    32'(-LIM - 1),
    32'(LVL),
    32'(LVL + 1),
    32'(LVL + 1),
    32'(-LVL),
    32'(-LVL - 1),
    32'(-LVL - 1),
    32'(ONE / 2),
    32'(LIM),
    32'(3 * ONE),
    32'(-LIM),
    32'(LIM),
    32'(-ONE),
    32'sh5555_5555,
    32'shAAAA_AAAA,
    32'(-ONE / 2),
    32'sd0
  };

  lookahead_soft_clipper i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one beat at the falling edge and hold it until taken
  task automatic send_sample(input logic signed [31:0] v);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i  = 1'b0;
      sample_in_i = $urandom;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    sample_in_i = v;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_sample(v);
    sent++;
  endtask

  // Drop valid, then block until every owed output beat has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tracker.outstanding() > 0) @(posedge clk_i);
  endtask

  // Output side: random back-pressure, changed on the falling edge
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.match_output(sample_out_o);
  end

  initial begin
    int     n_rand;
    int     roll;
    int     len;
    longint amp;
    longint walk;
    longint step;

    n_rand = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (corner_samples[k]) send_sample(corner_samples[k]);

    // Hold the sender off until the output side has caught up
    drain();

    while (n_rand < N_RAND) begin
      // One stretch in every four runs without idling, the others with it
      steady = ((n_rand / 150) % 4 == 2);
      if (n_rand >= N_RAND / 2 && n_rand < N_RAND / 2 + 30) drain();

      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        // Random walk around the clip level; a few swing past the clamp
        if ($urandom_range(0, 3) == 0)
          amp = $urandom_range(32'(ONE * 2), 32'(ONE * 9 / 2));
        else
          amp = $urandom_range(32'(ONE * 3 / 4), 32'(ONE * 8 / 5));
        len  = $urandom_range(4, 24);
        walk = longint'($urandom_range(0, 32'(2 * amp))) - amp;
        repeat (len) begin
          step = longint'($urandom_range(0, 32'(amp))) - amp / 2;
          walk += step;
          if (walk > amp) walk = amp;
          if (walk < -amp) walk = -amp;
          send_sample(32'(walk));
          n_rand++;
        end
      end else if (roll < 90) begin
        // Single sample a hair either side of +/- level
        walk = LVL + longint'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 1) == 1) walk = -walk;
        send_sample(32'(walk));
        n_rand++;
      end else begin
        // Full-range noise, far beyond the clamp
        send_sample($urandom);
        n_rand++;
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    drain();
    repeat (40) @(posedge clk_i);

    $display("Sent %0d samples (%0d corner, %0d random), checked %0d output beats.",
             sent, $size(corner_samples), n_rand, tracker.matched);
    $display("Saw %0d positive and %0d negative clip crossings.",
             tracker.pos_hits, tracker.neg_hits);
    if (tracker.errors == 0 && tracker.outstanding() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Timeout with %0d output beats still owed.", tracker.outstanding());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
